[sv/assert_macros.svh]
// Assertion macros shared by the binary signal table RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bst_pkg.sv]
// Package for the binary signal table: operation and status codes,
// controller states and the control structs between the table modules. No dependencies.
`default_nettype none

package bst_pkg;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_WAIT   = 2'd2;
  localparam logic [1:0] OP_SIGNAL = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ERROR   = 2'd1;
  localparam logic [1:0] STAT_BLOCKED = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic take;
    logic drop;
  } use_cmd_t;

  typedef struct packed {
    logic table_full;
    logic in_use;
  } use_stat_t;

endpackage

`default_nettype wire

[sv/bst_entry_mem.sv]
// Synchronous single-port-write, single-port-read memory with registered read data.
// Holds the per-entry value, waiter flag and waiter process. No dependencies.
`default_nettype none

module bst_entry_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/bst_use_map.sv]
// In-use map of the binary signal table: a row memory of in-use bits, per-row valid
// and full flags, and the lowest-free-entry search. Depends on bst_pkg.
`default_nettype none

module bst_use_map #(
  parameter int TABLE_ENTRIES = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             rd_en,
  input  wire logic                             rd_alloc,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] rd_id,
  input  wire bst_pkg::use_cmd_t                cmd,
  output bst_pkg::use_stat_t                    stat,
  output logic      [$clog2(TABLE_ENTRIES)-1:0] alloc_id
);

  localparam int AW     = $clog2(TABLE_ENTRIES);
  localparam int COL_W  = (AW < 5) ? AW : 5;
  localparam int ROW_W  = 1 << COL_W;
  localparam int ROWS   = (TABLE_ENTRIES + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IXW    = ROW_AW + COL_W + 1;

  logic [ROW_W-1:0]  row_mem [ROWS];
  logic [ROW_W-1:0]  rd_word;
  logic [ROWS-1:0]   row_valid;
  logic [ROWS-1:0]   full;
  logic [ROW_AW-1:0] row;
  logic [COL_W-1:0]  col;
  logic              all_full;
  logic [ROW_AW-1:0] pick_row;
  logic [ROW_AW-1:0] rd_row;
  logic [ROW_W-1:0]  word;
  logic [ROW_W-1:0]  tail_mask;
  logic [ROW_W-1:0]  eff;
  logic [ROW_W-1:0]  take_bit;
  logic [COL_W-1:0]  free_col;
  logic [IXW-1:0]    ix;

  always_comb begin
    pick_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!full[r]) begin
        pick_row = ROW_AW'(r);
      end
    end
    rd_row = rd_alloc ? pick_row : ROW_AW'(rd_id >> COL_W);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word  <= row_mem[rd_row];
      row      <= rd_row;
      col      <= COL_W'(rd_id);
      all_full <= &full;
    end
  end

  always_comb begin
    word = row_valid[row] ? rd_word : '0;
    ix   = '0;
    for (int c = 0; c < ROW_W; c++) begin
      ix           = {1'b0, row, COL_W'(c)};
      tail_mask[c] = (ix >= IXW'(TABLE_ENTRIES));
    end
    eff      = word | tail_mask;
    free_col = '0;
    for (int c = ROW_W - 1; c >= 0; c--) begin
      if (!eff[c]) begin
        free_col = COL_W'(c);
      end
    end
    take_bit        = ROW_W'(1) << free_col;
    alloc_id        = AW'({row, free_col});
    stat.table_full = all_full;
    stat.in_use     = word[col];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      row_mem[row] <= word | take_bit;
    end else if (cmd.drop) begin
      row_mem[row] <= word & ~(ROW_W'(1) << col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      full      <= '0;
    end else if (cmd.take) begin
      row_valid[row] <= 1'b1;
      full[row]      <= &(eff | take_bit);
    end else if (cmd.drop) begin
      row_valid[row] <= 1'b1;
      full[row]      <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[sv/binary_signal_table_core.sv]
// An accepted operation moves the controller from S_IDLE to S_EXEC, and done is
// registered from S_EXEC. busy is high in S_EXEC, so no new operation is taken until
// the read and the write-back of the in-use row memory and the entry memory are done.
// Reset: rst clears the controller and the per-row valid and full flags at once,
// so the table reads as empty with no clearing pass. Results cannot be stalled.
`default_nettype none

module binary_signal_table_core #(
  parameter int TABLE_ENTRIES = 128,
  parameter int PROCESS_COUNT = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       operation,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] signal_id,
  input  wire logic [$clog2(PROCESS_COUNT)-1:0] process_id,
  output logic                                  done,
  output logic      [1:0]                       status,
  output logic      [$clog2(TABLE_ENTRIES)-1:0] new_id,
  output logic                                  wake_valid,
  output logic      [$clog2(PROCESS_COUNT)-1:0] wake_process
);

`include "assert_macros.svh"

  localparam int AW       = $clog2(TABLE_ENTRIES);
  localparam int PW       = $clog2(PROCESS_COUNT);
  localparam int EW       = PW + 2;
  localparam int VAL_BIT  = PW + 1;
  localparam int WAIT_BIT = PW;

  bst_pkg::state_t    state;
  bst_pkg::state_t    state_next;
  bst_pkg::use_cmd_t  use_cmd;
  bst_pkg::use_stat_t use_stat;

  logic          accept;
  logic [1:0]    cur_op;
  logic [AW-1:0] cur_id;
  logic [PW-1:0] cur_pid;
  logic [AW-1:0] alloc_id;
  logic [EW-1:0] ent_rdata;
  logic          ent_we;
  logic [AW-1:0] ent_waddr;
  logic [EW-1:0] ent_wdata;
  logic          id_ok;
  logic          pid_ok;
  logic          live;
  logic [1:0]    status_c;
  logic [AW-1:0] new_id_c;
  logic          wake_c;
  logic [PW-1:0] wake_proc_c;

  assign accept = start && !busy;

  bst_use_map #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_use_map (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_alloc (operation == bst_pkg::OP_ALLOC),
    .rd_id    (signal_id),
    .cmd      (use_cmd),
    .stat     (use_stat),
    .alloc_id (alloc_id)
  );

  bst_entry_mem #(
    .DEPTH(TABLE_ENTRIES),
    .WIDTH(EW)
  ) u_entry_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (signal_id),
    .rd_data (ent_rdata),
    .wr_en   (ent_we),
    .wr_addr (ent_waddr),
    .wr_data (ent_wdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op  <= operation;
      cur_id  <= signal_id;
      cur_pid <= process_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    case (state)
      bst_pkg::S_IDLE: begin
        if (start) begin
          state_next = bst_pkg::S_EXEC;
        end
      end
      bst_pkg::S_EXEC: begin
        busy       = 1'b1;
        state_next = bst_pkg::S_IDLE;
      end
      default: begin
        state_next = bst_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    id_ok       = {1'b0, cur_id} < (AW + 1)'(TABLE_ENTRIES);
    pid_ok      = {1'b0, cur_pid} < (PW + 1)'(PROCESS_COUNT);
    live        = id_ok && use_stat.in_use;
    status_c    = bst_pkg::STAT_ERROR;
    new_id_c    = '0;
    wake_c      = 1'b0;
    wake_proc_c = '0;
    use_cmd     = '0;
    ent_we      = 1'b0;
    ent_waddr   = cur_id;
    ent_wdata   = ent_rdata;
    case (cur_op)
      bst_pkg::OP_ALLOC: begin
        if (!use_stat.table_full) begin
          status_c     = bst_pkg::STAT_OK;
          new_id_c     = alloc_id;
          use_cmd.take = 1'b1;
          ent_we       = 1'b1;
          ent_waddr    = alloc_id;
          ent_wdata    = '0;
        end
      end
      bst_pkg::OP_FREE: begin
        if (live) begin
          status_c     = bst_pkg::STAT_OK;
          use_cmd.drop = 1'b1;
        end
      end
      bst_pkg::OP_WAIT: begin
        if (live && !ent_rdata[WAIT_BIT] && pid_ok) begin
          ent_we = 1'b1;
          if (ent_rdata[VAL_BIT]) begin
            status_c           = bst_pkg::STAT_OK;
            ent_wdata[VAL_BIT] = 1'b0;
          end else begin
            status_c            = bst_pkg::STAT_BLOCKED;
            ent_wdata[WAIT_BIT] = 1'b1;
            ent_wdata[PW-1:0]   = cur_pid;
          end
        end
      end
      bst_pkg::OP_SIGNAL: begin
        if (live) begin
          status_c = bst_pkg::STAT_OK;
          ent_we   = 1'b1;
          if (ent_rdata[WAIT_BIT]) begin
            wake_c              = 1'b1;
            wake_proc_c         = ent_rdata[PW-1:0];
            ent_wdata[VAL_BIT]  = 1'b0;
            ent_wdata[WAIT_BIT] = 1'b0;
          end else begin
            ent_wdata[VAL_BIT] = 1'b1;
          end
        end
      end
      default: begin
        status_c = bst_pkg::STAT_ERROR;
      end
    endcase
    if (state != bst_pkg::S_EXEC) begin
      use_cmd = '0;
      ent_we  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == bst_pkg::S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == bst_pkg::S_EXEC) begin
      status       <= status_c;
      new_id       <= new_id_c;
      wake_valid   <= wake_c;
      wake_process <= wake_proc_c;
    end
  end

  `BST_ASSERT_NEXT(a_accept_to_exec, accept, state == bst_pkg::S_EXEC,
                   "accepted word did not enter execute")
  `BST_ASSERT_NEXT(a_exec_to_done, state == bst_pkg::S_EXEC, done && !busy,
                   "execute did not produce one result")
  `BST_ASSERT_SAME(a_wake_is_ok, done && wake_valid, status == bst_pkg::STAT_OK,
                   "wake with non-ok status")
  `BST_ASSERT_SAME(a_new_id_only_ok, done && (new_id != '0), status == bst_pkg::STAT_OK,
                   "new_id set on failure")

endmodule

`default_nettype wire

[test/binary_signal_table_core_tb.sv]
// Self-checking testbench for binary_signal_table_core, the table of binary signal entries.
// A directed table, checked against its typed replies or an in-bench table model, and then
// random calls checked against the model. Depends on bst_pkg and binary_signal_table_core.
`timescale 1ns / 1ps

module binary_signal_table_core_tb;

  localparam int ENTRIES = 128;
  localparam int PROCS = 256;
  localparam int RANDOM_WORDS = 1150;
  localparam int QUIET_TAIL = 200;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [$clog2(ENTRIES)-1:0] id_t;
  typedef logic [$clog2(PROCS)-1:0] pid_t;

  typedef struct packed {
    logic [1:0] status;
    id_t        new_id;
    logic       wake_valid;
    pid_t       wake_process;
  } table_reply_t;

  typedef struct {
    logic [1:0]   op;
    id_t          id;
    pid_t         pid;
    bit           typed;
    table_reply_t reply;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] operation = bst_pkg::OP_ALLOC;
  id_t signal_id = '0;
  pid_t process_id = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  id_t new_id;
  logic wake_valid;
  pid_t wake_process;

  bit slot_used [ENTRIES];
  bit slot_value [ENTRIES];
  bit slot_has_waiter [ENTRIES];
  pid_t slot_waiter [ENTRIES];

  table_reply_t pending_replies[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  binary_signal_table_core #(
    .TABLE_ENTRIES(ENTRIES),
    .PROCESS_COUNT(PROCS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .signal_id(signal_id),
    .process_id(process_id),
    .done(done),
    .status(status),
    .new_id(new_id),
    .wake_valid(wake_valid),
    .wake_process(wake_process)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic table_reply_t apply_signal_op(logic [1:0] op, id_t id, pid_t pid);
    table_reply_t r;
    r = '{status: bst_pkg::STAT_ERROR, new_id: '0, wake_valid: 1'b0, wake_process: '0};
    case (op)
      bst_pkg::OP_ALLOC: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_value[i] = 1'b0;
            slot_has_waiter[i] = 1'b0;
            r.new_id = id_t'(i);
            r.status = bst_pkg::STAT_OK;
            break;
          end
        end
      end
      bst_pkg::OP_FREE: begin
        if (slot_used[id]) begin
          slot_used[id] = 1'b0;
          r.status = bst_pkg::STAT_OK;
        end
      end
      bst_pkg::OP_WAIT: begin
        if (slot_used[id] && !slot_has_waiter[id] && int'(pid) < PROCS) begin
          if (slot_value[id]) begin
            slot_value[id] = 1'b0;
            r.status = bst_pkg::STAT_OK;
          end else begin
            slot_has_waiter[id] = 1'b1;
            slot_waiter[id] = pid;
            r.status = bst_pkg::STAT_BLOCKED;
          end
        end
      end
      default: begin
        if (slot_used[id]) begin
          slot_value[id] = 1'b1;
          if (slot_has_waiter[id]) begin
            r.wake_valid = 1'b1;
            r.wake_process = slot_waiter[id];
            slot_value[id] = 1'b0;
            slot_has_waiter[id] = 1'b0;
          end
          r.status = bst_pkg::STAT_OK;
        end
      end
    endcase
    return r;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) n += slot_used[i];
    return n;
  endfunction

  function automatic id_t pick_entry();
    int first;
    int k;
    first = $urandom_range(0, ENTRIES - 1);
    if ($urandom_range(0, 99) < 15) return id_t'(first);
    for (int i = 0; i < ENTRIES; i++) begin
      k = (first + i) % ENTRIES;
      if (slot_used[k]) return id_t'(k);
    end
    return id_t'(first);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [1:0] op, input id_t id, input pid_t pid,
                           input bit typed, input table_reply_t typed_reply);
    table_reply_t predicted;
    start <= 1'b1;
    operation <= op;
    signal_id <= id;
    process_id <= pid;
    do @(posedge clk); while (busy);
    predicted = apply_signal_op(op, id, pid);
    pending_replies.push_back(typed ? typed_reply : predicted);
    @(negedge clk);
  endtask

  task automatic send_random(input logic [1:0] op);
    send_word(op, pick_entry(), pid_t'($urandom_range(0, PROCS - 1)), 1'b0, '0);
  endtask

  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(negedge clk);
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  // Fill the table past full, then free it back down to a handful of entries.
  task automatic fill_and_drain();
    drain_replies();
    while (live_count() < ENTRIES) begin
      send_random(bst_pkg::OP_ALLOC);
      sender_gap();
    end
    repeat (3) send_random(bst_pkg::OP_ALLOC);
    while (live_count() > 6) begin
      send_word(bst_pkg::OP_FREE, pick_entry(), pid_t'($urandom), 1'b0, '0);
      sender_gap();
    end
  endtask

  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        $error("result word with nothing pending: status %0d", status);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (new_id !== want.new_id) begin
          $error("new_id: expected %0d, got %0d", want.new_id, new_id);
          mismatches++;
        end
        if (wake_valid !== want.wake_valid) begin
          $error("wake_valid: expected %0d, got %0d", want.wake_valid, wake_valid);
          mismatches++;
        end
        if (wake_process !== want.wake_process) begin
          $error("wake_process: expected %0d, got %0d", want.wake_process, wake_process);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t directed [24];
    int pick;
    int n;
    logic [1:0] op;

    directed = '{
      '{bst_pkg::OP_ALLOC,  7'd0,   8'd0,   1'b1, '{bst_pkg::STAT_OK,      7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_ALLOC,  7'd127, 8'd255, 1'b1, '{bst_pkg::STAT_OK,      7'd1, 1'b0, 8'd0}},
      '{bst_pkg::OP_FREE,   7'd127, 8'd0,   1'b1, '{bst_pkg::STAT_ERROR,   7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_WAIT,   7'd64,  8'd1,   1'b1, '{bst_pkg::STAT_ERROR,   7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_SIGNAL, 7'd127, 8'd0,   1'b1, '{bst_pkg::STAT_ERROR,   7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_SIGNAL, 7'd0,   8'd0,   1'b0, '0},
      '{bst_pkg::OP_WAIT,   7'd0,   8'd0,   1'b0, '0},
      '{bst_pkg::OP_WAIT,   7'd0,   8'd255, 1'b1, '{bst_pkg::STAT_BLOCKED, 7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_WAIT,   7'd0,   8'd3,   1'b1, '{bst_pkg::STAT_ERROR,   7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_SIGNAL, 7'd0,   8'd170, 1'b1, '{bst_pkg::STAT_OK,      7'd0, 1'b1, 8'd255}},
      '{bst_pkg::OP_SIGNAL, 7'd0,   8'd85,  1'b0, '0},
      '{bst_pkg::OP_FREE,   7'd0,   8'd0,   1'b0, '0},
      '{bst_pkg::OP_WAIT,   7'd1,   8'd0,   1'b0, '0},
      '{bst_pkg::OP_FREE,   7'd1,   8'd0,   1'b1, '{bst_pkg::STAT_OK,      7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_SIGNAL, 7'd1,   8'd0,   1'b1, '{bst_pkg::STAT_ERROR,   7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_ALLOC,  7'd85,  8'd170, 1'b1, '{bst_pkg::STAT_OK,      7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_ALLOC,  7'd42,  8'd15,  1'b1, '{bst_pkg::STAT_OK,      7'd1, 1'b0, 8'd0}},
      '{bst_pkg::OP_WAIT,   7'd0,   8'd7,   1'b0, '0},
      '{bst_pkg::OP_SIGNAL, 7'd1,   8'd0,   1'b0, '0},
      '{bst_pkg::OP_SIGNAL, 7'd0,   8'd42,  1'b0, '0},
      '{bst_pkg::OP_FREE,   7'd0,   8'd0,   1'b0, '0},
      '{bst_pkg::OP_FREE,   7'd1,   8'd0,   1'b0, '0},
      '{bst_pkg::OP_ALLOC,  7'd0,   8'd0,   1'b1, '{bst_pkg::STAT_OK,      7'd0, 1'b0, 8'd0}},
      '{bst_pkg::OP_FREE,   7'd0,   8'd0,   1'b0, '0}
    };

    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_value[i] = 1'b0;
      slot_has_waiter[i] = 1'b0;
      slot_waiter[i] = '0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      send_word(directed[i].op, directed[i].id, directed[i].pid, directed[i].typed,
                directed[i].reply);
      sender_gap();
    end
    drain_replies();

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (k >= RANDOM_WORDS - QUIET_TAIL) gaps_on = 1'b0;
      if (k == 500 || k == 1100) fill_and_drain();
      n = live_count();
      pick = $urandom_range(0, 99);
      if (n == 0) op = (pick < 70) ? bst_pkg::OP_ALLOC : pick[1:0];
      else if (pick < ((n < 8) ? 35 : 15)) op = bst_pkg::OP_ALLOC;
      else if (pick < ((n < 8) ? 45 : 30)) op = bst_pkg::OP_FREE;
      else if (pick < 65) op = bst_pkg::OP_WAIT;
      else op = bst_pkg::OP_SIGNAL;
      send_random(op);
      sender_gap();
    end

    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
